@@ src/bni_pkg.sv @@
// ----------------------------------------------------------------------------
// bni_pkg
// shared types and constants for the bilinear no-data interpolator
// ----------------------------------------------------------------------------
package bni_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int ELEV_BITS   = 32;

   // sum of up to four valid samples
   localparam int SUM_BITS   = SAMPLE_BITS + 2;
   localparam int COUNT_BITS = 3;

   // divide by three: q = (s * ceil(2^20 / 3)) >> 20, exact for s < 2^19
   localparam int                  DIV3_SHIFT = 20;
   localparam int                  RECIP_BITS = 19;
   localparam logic [RECIP_BITS-1:0] DIV3_RECIP = 19'd349526;
   localparam int                  QUOT_BITS  = SUM_BITS + RECIP_BITS - DIV3_SHIFT;

   localparam logic [COUNT_BITS-1:0] CNT_NONE  = 3'd0;
   localparam logic [COUNT_BITS-1:0] CNT_ONE   = 3'd1;
   localparam logic [COUNT_BITS-1:0] CNT_TWO   = 3'd2;
   localparam logic [COUNT_BITS-1:0] CNT_THREE = 3'd3;
   localparam logic [COUNT_BITS-1:0] CNT_ALL   = 3'd4;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] corner_nw;
      logic [SAMPLE_BITS-1:0] corner_ne;
      logic [SAMPLE_BITS-1:0] corner_sw;
      logic [SAMPLE_BITS-1:0] corner_se;
      logic [WEIGHT_BITS-1:0] frac_x;
      logic [WEIGHT_BITS-1:0] frac_y;
   } req_payload_type;

   typedef struct packed {
      logic [ELEV_BITS-1:0] elevation;
      logic                 no_data;
      logic                 corners_filled;
   } rsp_payload_type;

endpackage

@@ src/bni_lerp.sv @@
// ----------------------------------------------------------------------------
// bni_lerp
// two-stage linear blend: a + floor((b - a) * t / 2^16)
// ----------------------------------------------------------------------------
module bni_lerp
   import bni_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic [VALUE_BITS-1:0]  in_a,
   input  logic [VALUE_BITS-1:0]  in_b,
   input  logic [WEIGHT_BITS-1:0] in_t,
   output logic [VALUE_BITS-1:0]  out_value
);

   localparam int DIFF_BITS = VALUE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + WEIGHT_BITS + 1;

   logic signed [DIFF_BITS-1:0] diff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic [VALUE_BITS-1:0]       a_ff;
   logic signed [PROD_BITS-1:0] step;
   logic [VALUE_BITS-1:0]       value_in;
   logic [VALUE_BITS-1:0]       value_ff;

   // stage one: signed difference times weight
   always_comb begin
      diff    = $signed({1'b0, in_b}) - $signed({1'b0, in_a});
      prod_in = PROD_BITS'(diff) * $signed({{(PROD_BITS-WEIGHT_BITS){1'b0}}, in_t});
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= in_a;
   end

   // stage two: arithmetic shift floors, result stays between a and b
   always_comb begin
      step     = prod_ff >>> WEIGHT_BITS;
      value_in = a_ff + step[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign out_value = value_ff;

endmodule

@@ src/bilinear_nodata_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_nodata_interpolator_core
// bilinear elevation blend of one grid cell with no-data corner fill
// ----------------------------------------------------------------------------
// one cell enters per clock and its result comes out of the last stage as a
// one-cycle rsp_valid strobe; busy never rises, so start may be held high
// for a full-rate stream. the seven stages are: corner classify and valid
// sum, divide-by-three reciprocal multiply, fill average and corner
// substitution, then two stages each for the x blend and the y blend
// (multiply, then shift and add). the receiver cannot stall, so nothing
// backs up. nodata_code may only be written while no cell is in flight;
// csr_ready is always high. elevation is unsigned 16.FRACTION_BITS and
// saturates when wider than 32 bits.
// ----------------------------------------------------------------------------
module bilinear_nodata_interpolator_core
   import bni_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request beat
   input  logic                   start,
   output logic                   busy,
   input  req_payload_type        req_payload,
   // response beat
   output logic                   rsp_valid,
   output rsp_payload_type        rsp_payload,
   // no-data code register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SAMPLE_BITS-1:0] csr_data
);

   // corner value in 16.FRACTION_BITS
   localparam int VALUE_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int PROD3_BITS = SUM_BITS + RECIP_BITS;
   localparam int WIDE_BITS  = VALUE_BITS + ELEV_BITS;

   // fractional part of a third and of two thirds, truncated
   localparam longint                   ONE_SCALED  = longint'(1) << FRACTION_BITS;
   localparam logic [FRACTION_BITS-1:0] THIRD_FRAC  = FRACTION_BITS'(ONE_SCALED / 3);
   localparam logic [FRACTION_BITS-1:0] THIRDS_FRAC = FRACTION_BITS'((2 * ONE_SCALED) / 3);

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] nodata_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodata_code_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         nodata_code_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // ---------------------------------------------------------------------
   // stage 1: classify corners, sum and count the valid ones
   // ---------------------------------------------------------------------
   logic [3:0][SAMPLE_BITS-1:0] raw;
   logic [3:0]                  miss_in;
   logic [SUM_BITS-1:0]         sum_in;
   logic [COUNT_BITS-1:0]       cnt_in;

   logic                        s1_valid_ff;
   logic [3:0][SAMPLE_BITS-1:0] s1_raw_ff;
   logic [3:0]                  s1_miss_ff;
   logic [SUM_BITS-1:0]         s1_sum_ff;
   logic [COUNT_BITS-1:0]       s1_cnt_ff;
   logic [WEIGHT_BITS-1:0]      s1_fx_ff;
   logic [WEIGHT_BITS-1:0]      s1_fy_ff;

   always_comb begin
      raw[0] = req_payload.corner_nw;
      raw[1] = req_payload.corner_ne;
      raw[2] = req_payload.corner_sw;
      raw[3] = req_payload.corner_se;
      sum_in = '0;
      cnt_in = '0;
      for (int i = 0; i < 4; i++) begin
         miss_in[i] = (raw[i] == nodata_code_ff);
         if (!miss_in[i]) begin
            sum_in = sum_in + SUM_BITS'(raw[i]);
            cnt_in = cnt_in + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_raw_ff  <= raw;
      s1_miss_ff <= miss_in;
      s1_sum_ff  <= sum_in;
      s1_cnt_ff  <= cnt_in;
      s1_fx_ff   <= req_payload.frac_x;
      s1_fy_ff   <= req_payload.frac_y;
   end

   // ---------------------------------------------------------------------
   // stage 2: quotient of the sum by three through the reciprocal
   // ---------------------------------------------------------------------
   logic [PROD3_BITS-1:0]       prod3;

   logic                        s2_valid_ff;
   logic [3:0][SAMPLE_BITS-1:0] s2_raw_ff;
   logic [3:0]                  s2_miss_ff;
   logic [SUM_BITS-1:0]         s2_sum_ff;
   logic [COUNT_BITS-1:0]       s2_cnt_ff;
   logic [WEIGHT_BITS-1:0]      s2_fx_ff;
   logic [WEIGHT_BITS-1:0]      s2_fy_ff;
   logic [QUOT_BITS-1:0]        s2_q3_ff;

   assign prod3 = PROD3_BITS'(s1_sum_ff) * PROD3_BITS'(DIV3_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_raw_ff  <= s1_raw_ff;
      s2_miss_ff <= s1_miss_ff;
      s2_sum_ff  <= s1_sum_ff;
      s2_cnt_ff  <= s1_cnt_ff;
      s2_fx_ff   <= s1_fx_ff;
      s2_fy_ff   <= s1_fy_ff;
      s2_q3_ff   <= prod3[PROD3_BITS-1:DIV3_SHIFT];
   end

   // ---------------------------------------------------------------------
   // stage 3: fill average and substitution of missing corners
   // ---------------------------------------------------------------------
   logic [SUM_BITS:0]            rem_full;
   logic [FRACTION_BITS-1:0]     rem_frac;
   logic [VALUE_BITS-1:0]        avg;
   logic [3:0][VALUE_BITS-1:0]   fill_in;

   logic                         s3_valid_ff;
   logic [3:0][VALUE_BITS-1:0]   s3_val_ff;
   logic [WEIGHT_BITS-1:0]       s3_fx_ff;
   logic [WEIGHT_BITS-1:0]       s3_fy_ff;
   logic                         s3_nodata_ff;
   logic                         s3_filled_ff;

   always_comb begin
      // remainder of the sum by three, always 0..2
      rem_full = {1'b0, s2_sum_ff} - ((SUM_BITS + 1)'(s2_q3_ff) * (SUM_BITS + 1)'(3));
      unique case (rem_full[1:0])
         2'd1:    rem_frac = THIRD_FRAC;
         2'd2:    rem_frac = THIRDS_FRAC;
         default: rem_frac = '0;
      endcase

      unique case (s2_cnt_ff)
         CNT_ONE:   avg = VALUE_BITS'(s2_sum_ff) << FRACTION_BITS;
         CNT_TWO:   avg = VALUE_BITS'(s2_sum_ff) << (FRACTION_BITS - 1);
         CNT_THREE: avg = {s2_q3_ff[SAMPLE_BITS-1:0], rem_frac};
         default:   avg = '0;
      endcase

      for (int i = 0; i < 4; i++) begin
         fill_in[i] = s2_miss_ff[i] ? avg : {s2_raw_ff[i], {FRACTION_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_val_ff    <= fill_in;
      s3_fx_ff     <= s2_fx_ff;
      s3_fy_ff     <= s2_fy_ff;
      s3_nodata_ff <= (s2_cnt_ff == CNT_NONE);
      s3_filled_ff <= (s2_cnt_ff != CNT_NONE) && (s2_cnt_ff != CNT_ALL);
   end

   // ---------------------------------------------------------------------
   // stages 4-5: blend along x, top and bottom rows in parallel
   // ---------------------------------------------------------------------
   logic [VALUE_BITS-1:0]  top_value;
   logic [VALUE_BITS-1:0]  bot_value;

   logic [1:0]             xs_valid_ff;
   logic [WEIGHT_BITS-1:0] xs_fy_ff [2];
   logic [1:0]             xs_nodata_ff;
   logic [1:0]             xs_filled_ff;

   bni_lerp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_lerp_top (
      .clock     (clock),
      .in_a      (s3_val_ff[0]),
      .in_b      (s3_val_ff[1]),
      .in_t      (s3_fx_ff),
      .out_value (top_value)
   );

   bni_lerp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_lerp_bot (
      .clock     (clock),
      .in_a      (s3_val_ff[2]),
      .in_b      (s3_val_ff[3]),
      .in_t      (s3_fx_ff),
      .out_value (bot_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         xs_valid_ff <= '0;
      end else begin
         xs_valid_ff <= {xs_valid_ff[0], s3_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      xs_fy_ff[0]  <= s3_fy_ff;
      xs_fy_ff[1]  <= xs_fy_ff[0];
      xs_nodata_ff <= {xs_nodata_ff[0], s3_nodata_ff};
      xs_filled_ff <= {xs_filled_ff[0], s3_filled_ff};
   end

   // ---------------------------------------------------------------------
   // stages 6-7: blend along y, then saturate to 32 bits
   // ---------------------------------------------------------------------
   logic [VALUE_BITS-1:0] mid_value;
   logic [WIDE_BITS-1:0]  wide_value;
   logic [ELEV_BITS-1:0]  elev_sat;

   logic [1:0]            ys_valid_ff;
   logic [1:0]            ys_nodata_ff;
   logic [1:0]            ys_filled_ff;

   bni_lerp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_lerp_mid (
      .clock     (clock),
      .in_a      (top_value),
      .in_b      (bot_value),
      .in_t      (xs_fy_ff[1]),
      .out_value (mid_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ys_valid_ff <= '0;
      end else begin
         ys_valid_ff <= {ys_valid_ff[0], xs_valid_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      ys_nodata_ff <= {ys_nodata_ff[0], xs_nodata_ff[1]};
      ys_filled_ff <= {ys_filled_ff[0], xs_filled_ff[1]};
   end

   always_comb begin
      wide_value = WIDE_BITS'(mid_value);
      if (|wide_value[WIDE_BITS-1:ELEV_BITS]) begin
         elev_sat = '1;
      end else begin
         elev_sat = wide_value[ELEV_BITS-1:0];
      end
   end

   // response beat, a single-cycle strobe
   always_comb begin
      rsp_valid                  = ys_valid_ff[1];
      rsp_payload.elevation      = ys_nodata_ff[1] ? '0 : elev_sat;
      rsp_payload.no_data        = ys_nodata_ff[1];
      rsp_payload.corners_filled = ys_filled_ff[1];
   end

endmodule
